[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/ebcpu_pkg.sv]
// Package for the 8-bit CPU execute unit: operation codes, flag bits, queue item type.
// No dependencies.
package ebcpu_pkg;
  localparam int QueueDepth = 2;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0, OP_SBC = 6'd1, OP_AND = 6'd2, OP_ORA = 6'd3, OP_EOR = 6'd4,
    OP_CMP = 6'd5, OP_CPX = 6'd6, OP_CPY = 6'd7, OP_BIT = 6'd8, OP_LDA = 6'd9,
    OP_LDX = 6'd10, OP_LDY = 6'd11, OP_ASLM = 6'd12, OP_ASLA = 6'd13,
    OP_LSRM = 6'd14, OP_LSRA = 6'd15, OP_ROLM = 6'd16, OP_ROLA = 6'd17,
    OP_RORM = 6'd18, OP_RORA = 6'd19, OP_INC = 6'd20, OP_DEC = 6'd21,
    OP_INX = 6'd22, OP_INY = 6'd23, OP_DEX = 6'd24, OP_DEY = 6'd25,
    OP_TAX = 6'd26, OP_TAY = 6'd27, OP_TSX = 6'd28, OP_TXA = 6'd29,
    OP_TXS = 6'd30, OP_TYA = 6'd31, OP_CLC = 6'd32, OP_CLD = 6'd33,
    OP_CLI = 6'd34, OP_CLV = 6'd35, OP_SEC = 6'd36, OP_SED = 6'd37,
    OP_SEI = 6'd38, OP_STA = 6'd39, OP_STX = 6'd40, OP_STY = 6'd41,
    OP_BCC = 6'd42, OP_BCS = 6'd43, OP_BEQ = 6'd44, OP_BMI = 6'd45,
    OP_BNE = 6'd46, OP_BPL = 6'd47, OP_BVC = 6'd48, OP_BVS = 6'd49,
    OP_NOP = 6'd50
  } op_t;

  typedef enum logic [1:0] {
    CLS_ALU = 2'd0, CLS_SHIFT = 2'd1, CLS_MOVE = 2'd2, CLS_CTRL = 2'd3
  } cls_t;

  localparam int FlC = 0;
  localparam int FlZ = 1;
  localparam int FlI = 2;
  localparam int FlD = 3;
  localparam int FlV = 6;
  localparam int FlN = 7;

  localparam logic [7:0] FlagsReset = 8'h36;
  localparam logic [7:0] SpReset    = 8'hFF;

  typedef struct packed {
    op_t        op;
    cls_t       cls;
    logic [7:0] operand;
  } item_t;
endpackage

[rtl/core/ebcpu_front.sv]
// Front end: accepts operations, classifies them and queues them for the back end.
// Depends on ebcpu_pkg.
module ebcpu_front import ebcpu_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_cmd,
  input  logic [7:0] in_operand,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  item_t          cls_item;
  logic           push, pop;

  always_comb begin
    cls_item.operand = in_operand;
    if (in_cmd > 6'd50) begin
      cls_item.op = OP_NOP;
    end else begin
      cls_item.op = op_t'(in_cmd);
    end
    if (in_cmd <= 6'd11) cls_item.cls = CLS_ALU;
    else if (in_cmd <= 6'd25) cls_item.cls = CLS_SHIFT;
    else if (in_cmd <= 6'd41) cls_item.cls = CLS_MOVE;
    else cls_item.cls = CLS_CTRL;
  end

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[rtl/core/ebcpu_back.sv]
// Back end: executes one queued operation per cycle while the output is not stalled, registered result.
// Depends on ebcpu_pkg.
module ebcpu_back import ebcpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser
);
  logic [7:0] a_r, x_r, y_r, s_r, p_r;
  logic [7:0] a_nxt, x_nxt, y_nxt, s_nxt, p_nxt;
  logic [7:0] mv, mv_r;
  logic       mw, br, mw_r, br_r, ov_r;
  logic       fire;
  logic [7:0] v;
  logic       c;
  logic [8:0] sum;
  logic [9:0] dsum;
  logic [15:0] t;
  logic [7:0] shr_in;
  logic [8:0] cmp_d;
  logic [7:0] cmp_reg, res8;

  assign q_ready = !ov_r || out_tready;
  assign fire    = q_valid && q_ready;
  assign v = q_item.operand;
  assign c = p_r[FlC];

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    mv = 8'h00; mw = 1'b0; br = 1'b0;
    sum = 9'd0; dsum = 10'd0; t = 16'd0; shr_in = 8'd0; cmp_d = 9'd0;
    cmp_reg = a_r; res8 = 8'h00;
    unique case (q_item.op)
      OP_ADC: begin
        sum = {1'b0, a_r} + {1'b0, v} + {8'd0, c};
        dsum = {1'b0, sum};
        if (p_r[FlD]) begin
          if ({1'b0, a_r[3:0]} + {1'b0, v[3:0]} + {4'd0, c} > 5'd9) dsum = dsum + 10'd6;
          if (dsum > 10'h099) dsum = dsum + 10'h060;
        end
        p_nxt[FlC] = dsum > 10'h0FF;
        p_nxt[FlZ] = dsum[7:0] == 8'h00;
        p_nxt[FlV] = ~(a_r[7] ^ v[7]) & (a_r[7] ^ dsum[7]);
        p_nxt[FlN] = dsum[7];
        a_nxt = dsum[7:0];
      end
      OP_SBC: begin
        t = {8'd0, a_r} - {8'd0, v} - {15'd0, ~c};
        p_nxt[FlN] = t[7];
        p_nxt[FlZ] = t[7:0] == 8'h00;
        p_nxt[FlV] = (a_r[7] ^ t[7]) & (a_r[7] ^ v[7]);
        if (p_r[FlD]) begin
          if ({1'b0, a_r[3:0]} < {1'b0, v[3:0]} + {4'd0, ~c}) t = t - 16'd6;
          if (t > 16'h0099) t = t - 16'h0060;
        end
        p_nxt[FlC] = t < 16'h0100;
        a_nxt = t[7:0];
      end
      OP_AND, OP_ORA, OP_EOR, OP_LDA: begin
        if (q_item.op == OP_AND) res8 = a_r & v;
        else if (q_item.op == OP_ORA) res8 = a_r | v;
        else if (q_item.op == OP_EOR) res8 = a_r ^ v;
        else res8 = v;
        a_nxt = res8;
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        if (q_item.op == OP_CPX) cmp_reg = x_r;
        else if (q_item.op == OP_CPY) cmp_reg = y_r;
        cmp_d = {1'b0, cmp_reg} - {1'b0, v};
        p_nxt[FlC] = !cmp_d[8];
        p_nxt[FlZ] = cmp_d[7:0] == 8'h00;
        p_nxt[FlN] = cmp_d[7];
      end
      OP_BIT: begin
        p_nxt[FlN] = v[7]; p_nxt[FlV] = v[6]; p_nxt[FlZ] = (a_r & v) == 8'h00;
      end
      OP_LDX, OP_TAX, OP_TSX, OP_INX, OP_DEX: begin
        if (q_item.op == OP_LDX) res8 = v;
        else if (q_item.op == OP_TAX) res8 = a_r;
        else if (q_item.op == OP_TSX) res8 = s_r;
        else if (q_item.op == OP_INX) res8 = x_r + 8'd1;
        else res8 = x_r - 8'd1;
        x_nxt = res8;
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
      end
      OP_LDY, OP_TAY, OP_INY, OP_DEY: begin
        if (q_item.op == OP_LDY) res8 = v;
        else if (q_item.op == OP_TAY) res8 = a_r;
        else if (q_item.op == OP_INY) res8 = y_r + 8'd1;
        else res8 = y_r - 8'd1;
        y_nxt = res8;
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
      end
      OP_TXA, OP_TYA: begin
        res8 = (q_item.op == OP_TXA) ? x_r : y_r;
        a_nxt = res8;
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
      end
      OP_ASLM, OP_ASLA, OP_ROLM, OP_ROLA: begin
        shr_in = (q_item.op == OP_ASLM || q_item.op == OP_ROLM) ? v : a_r;
        res8 = {shr_in[6:0],
                (q_item.op == OP_ROLM || q_item.op == OP_ROLA) ? c : 1'b0};
        p_nxt[FlC] = shr_in[7];
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
        if (q_item.op == OP_ASLA || q_item.op == OP_ROLA) a_nxt = res8;
        else begin mv = res8; mw = 1'b1; end
      end
      OP_LSRM, OP_LSRA, OP_RORM, OP_RORA: begin
        shr_in = (q_item.op == OP_LSRM || q_item.op == OP_RORM) ? v : a_r;
        res8 = {(q_item.op == OP_RORM || q_item.op == OP_RORA) ? c : 1'b0,
                shr_in[7:1]};
        p_nxt[FlC] = shr_in[0];
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
        if (q_item.op == OP_LSRA || q_item.op == OP_RORA) a_nxt = res8;
        else begin mv = res8; mw = 1'b1; end
      end
      OP_INC, OP_DEC: begin
        res8 = (q_item.op == OP_INC) ? v + 8'd1 : v - 8'd1;
        mv = res8; mw = 1'b1;
        p_nxt[FlZ] = res8 == 8'h00; p_nxt[FlN] = res8[7];
      end
      OP_TXS: s_nxt = x_r;
      OP_CLC: p_nxt[FlC] = 1'b0;
      OP_CLD: p_nxt[FlD] = 1'b0;
      OP_CLI: p_nxt[FlI] = 1'b0;
      OP_CLV: p_nxt[FlV] = 1'b0;
      OP_SEC: p_nxt[FlC] = 1'b1;
      OP_SED: p_nxt[FlD] = 1'b1;
      OP_SEI: p_nxt[FlI] = 1'b1;
      OP_STA: begin mv = a_r; mw = 1'b1; end
      OP_STX: begin mv = x_r; mw = 1'b1; end
      OP_STY: begin mv = y_r; mw = 1'b1; end
      OP_BCC: br = !p_r[FlC];
      OP_BCS: br = p_r[FlC];
      OP_BEQ: br = p_r[FlZ];
      OP_BMI: br = p_r[FlN];
      OP_BNE: br = !p_r[FlZ];
      OP_BPL: br = !p_r[FlN];
      OP_BVC: br = !p_r[FlV];
      OP_BVS: br = p_r[FlV];
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; x_r <= '0; y_r <= '0; s_r <= SpReset; p_r <= FlagsReset; ov_r <= 1'b0;
    end else begin
      if (fire) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; p_r <= p_nxt;
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mv_r <= mv; mw_r <= mw; br_r <= br;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {s_r, p_r, y_r, x_r, a_r, mv_r};
  assign out_tuser  = {br_r, mw_r};
endmodule

[rtl/core/eight_bit_cpu_execute_unit.sv]
// Execute unit of an 8-bit accumulator CPU: top level joining front end, queue and back end.
// Path: an input transfer is written into the queue, then the back end registers the result.
// Throughput: one operation per cycle while the output is not stalled; the back end's execute sets the rate.
// Reset (rst_n low, synchronous): A/X/Y clear, SP = 0xFF, P = 0x36, queue and output empty.
// Depends on ebcpu_pkg, ebcpu_front, ebcpu_back.
module eight_bit_cpu_execute_unit import ebcpu_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] cmd, [13:6] operand, [15:14] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // mem_value, acc_now, x_now, y_now, flags_now, sp_now
  output logic [1:0]  out_tuser   // [0] mem_write, [1] branch_taken
);
  logic  q_valid, q_ready;
  item_t q_item;

  // Front end: classify and hold up to QUEUE_DEPTH operations.
  ebcpu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tdata[5:0]), .in_operand(in_tdata[13:6]),
    .q_valid, .q_ready, .q_item
  );

  // Back end: execute and register the result; advance whenever the output is free.
  ebcpu_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule

[rtl/core/ebcpu_checker.sv]
// Port-level checker for the execute unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ebcpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `CHK_IMPL(a_nowr, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[7:0] == 8'h00, "mem_value without write")
  `CHK_IMPL(a_flags, clk, rst_n, out_tvalid, out_tdata[37:36] == 2'b11, "B/unused flag bits changed")
  `CHK_NEXT(a_lat, clk, rst_n, in_tvalid && in_tready && !out_tvalid, ##1 out_tvalid, "result missing")
endmodule

bind eight_bit_cpu_execute_unit ebcpu_checker u_chk (.*);

[dv/eight_bit_cpu_execute_unit_tb.sv]
// Self-checking testbench for the 8-bit CPU execute unit: a directed table, then random
// instruction streams checked against a register-level predictor of A, X, Y, SP and P.
// Depends on ebcpu_pkg and the eight_bit_cpu_execute_unit RTL.
module eight_bit_cpu_execute_unit_tb;
  import ebcpu_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandomOps  = 1830;
  localparam int DrainWait  = 8;

  typedef struct packed {
    logic [7:0] mem_value;
    logic       mem_write;
    logic       branch_taken;
    logic [7:0] acc_now;
    logic [7:0] x_now;
    logic [7:0] y_now;
    logic [7:0] flags_now;
    logic [7:0] sp_now;
  } exec_result_t;

  // Directed row: the result is typed in only when check_fixed is set.
  typedef struct {
    logic [5:0]   cmd;
    logic [7:0]   operand;
    bit           check_fixed;
    exec_result_t fixed;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // Predictor copy of the architectural state.
  logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;

  exec_result_t pending_results[$];
  int           errors;
  int           cycles;
  int           sent_ops;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_off;

  eight_bit_cpu_execute_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Set or clear one status bit.
  function automatic void put_p(int bitpos, bit on);
    cpu_p[bitpos] = on;
  endfunction

  // Update Z and N from a byte and return it.
  function automatic logic [7:0] set_zn(logic [7:0] v);
    put_p(FlZ, v == 8'h00);
    put_p(FlN, v[7]);
    return v;
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] v);
    logic [7:0] d;
    d = r - v;
    put_p(FlC, r >= v);
    put_p(FlZ, r == v);
    put_p(FlN, d[7]);
  endfunction

  function automatic void add_with_carry(logic [7:0] v);
    int unsigned sum;
    int unsigned cin;
    cin = cpu_p[FlC];
    sum = cpu_a + v + cin;
    if (cpu_p[FlD]) begin
      if ((cpu_a & 8'h0F) + (v & 8'h0F) + cin > 9) sum += 6;
      if (sum > 'h99) sum += 'h60;
    end
    put_p(FlC, sum > 'hFF);
    put_p(FlZ, (sum & 'hFF) == 0);
    put_p(FlV, ((~(cpu_a ^ v)) & (cpu_a ^ sum[7:0]) & 8'h80) != 0);
    put_p(FlN, sum[7]);
    cpu_a = sum[7:0];
  endfunction

  function automatic void sub_with_borrow(logic [7:0] v);
    logic [15:0] diff;
    int          brw;
    brw  = cpu_p[FlC] ? 0 : 1;
    diff = {8'h00, cpu_a} - {8'h00, v} - 16'(brw);
    put_p(FlN, diff[7]);
    put_p(FlZ, diff[7:0] == 8'h00);
    put_p(FlV, ((cpu_a ^ diff[7:0]) & 8'h80) != 0 && ((cpu_a ^ v) & 8'h80) != 0);
    if (cpu_p[FlD]) begin
      if (int'(cpu_a & 8'h0F) - brw < int'(v & 8'h0F)) diff = diff - 16'd6;
      if (diff > 16'h0099) diff = diff - 16'h0060;
    end
    put_p(FlC, diff < 16'h0100);
    cpu_a = diff[7:0];
  endfunction

  function automatic logic [7:0] shift_left(logic [7:0] v, bit rot);
    logic c_in;
    c_in = rot & cpu_p[FlC];
    put_p(FlC, v[7]);
    return set_zn({v[6:0], c_in});
  endfunction

  function automatic logic [7:0] shift_right(logic [7:0] v, bit rot);
    logic c_in;
    c_in = rot & cpu_p[FlC];
    put_p(FlC, v[0]);
    return set_zn({c_in, v[7:1]});
  endfunction

  // Advance the predicted CPU state by one operation and return its result.
  function automatic exec_result_t execute_op(logic [5:0] cmd, logic [7:0] v);
    exec_result_t r;
    r = '0;
    case (cmd)
      OP_ADC:  add_with_carry(v);
      OP_SBC:  sub_with_borrow(v);
      OP_AND:  cpu_a = set_zn(cpu_a & v);
      OP_ORA:  cpu_a = set_zn(cpu_a | v);
      OP_EOR:  cpu_a = set_zn(cpu_a ^ v);
      OP_CMP:  compare_reg(cpu_a, v);
      OP_CPX:  compare_reg(cpu_x, v);
      OP_CPY:  compare_reg(cpu_y, v);
      OP_BIT: begin
        put_p(FlN, v[7]);
        put_p(FlV, v[6]);
        put_p(FlZ, (cpu_a & v) == 8'h00);
      end
      OP_LDA:  cpu_a = set_zn(v);
      OP_LDX:  cpu_x = set_zn(v);
      OP_LDY:  cpu_y = set_zn(v);
      OP_ASLM: begin r.mem_value = shift_left(v, 0);  r.mem_write = 1; end
      OP_ASLA: cpu_a = shift_left(cpu_a, 0);
      OP_LSRM: begin r.mem_value = shift_right(v, 0); r.mem_write = 1; end
      OP_LSRA: cpu_a = shift_right(cpu_a, 0);
      OP_ROLM: begin r.mem_value = shift_left(v, 1);  r.mem_write = 1; end
      OP_ROLA: cpu_a = shift_left(cpu_a, 1);
      OP_RORM: begin r.mem_value = shift_right(v, 1); r.mem_write = 1; end
      OP_RORA: cpu_a = shift_right(cpu_a, 1);
      OP_INC:  begin r.mem_value = set_zn(v + 8'd1); r.mem_write = 1; end
      OP_DEC:  begin r.mem_value = set_zn(v - 8'd1); r.mem_write = 1; end
      OP_INX:  cpu_x = set_zn(cpu_x + 8'd1);
      OP_INY:  cpu_y = set_zn(cpu_y + 8'd1);
      OP_DEX:  cpu_x = set_zn(cpu_x - 8'd1);
      OP_DEY:  cpu_y = set_zn(cpu_y - 8'd1);
      OP_TAX:  cpu_x = set_zn(cpu_a);
      OP_TAY:  cpu_y = set_zn(cpu_a);
      OP_TSX:  cpu_x = set_zn(cpu_sp);
      OP_TXA:  cpu_a = set_zn(cpu_x);
      OP_TXS:  cpu_sp = cpu_x;
      OP_TYA:  cpu_a = set_zn(cpu_y);
      OP_CLC:  put_p(FlC, 0);
      OP_CLD:  put_p(FlD, 0);
      OP_CLI:  put_p(FlI, 0);
      OP_CLV:  put_p(FlV, 0);
      OP_SEC:  put_p(FlC, 1);
      OP_SED:  put_p(FlD, 1);
      OP_SEI:  put_p(FlI, 1);
      OP_STA:  begin r.mem_value = cpu_a; r.mem_write = 1; end
      OP_STX:  begin r.mem_value = cpu_x; r.mem_write = 1; end
      OP_STY:  begin r.mem_value = cpu_y; r.mem_write = 1; end
      OP_BCC:  r.branch_taken = !cpu_p[FlC];
      OP_BCS:  r.branch_taken = cpu_p[FlC];
      OP_BEQ:  r.branch_taken = cpu_p[FlZ];
      OP_BMI:  r.branch_taken = cpu_p[FlN];
      OP_BNE:  r.branch_taken = !cpu_p[FlZ];
      OP_BPL:  r.branch_taken = !cpu_p[FlN];
      OP_BVC:  r.branch_taken = !cpu_p[FlV];
      OP_BVS:  r.branch_taken = cpu_p[FlV];
      default: ;  // NOP and the unused codes above it
    endcase
    r.acc_now   = cpu_a;
    r.x_now     = cpu_x;
    r.y_now     = cpu_y;
    r.flags_now = cpu_p;
    r.sp_now    = cpu_sp;
    return r;
  endfunction

  // Present one operation and hold it until the transfer; random idle cycles first.
  // Drop valid only while idling, so back-to-back items keep it high.
  task automatic send_op(logic [5:0] cmd, logic [7:0] v, bit check_fixed, exec_result_t fixed);
    exec_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v, cmd};
    predicted = execute_op(cmd, v);
    if (check_fixed && predicted !== fixed) begin
      $error("table row cmd %0d: typed result %h, predictor %h", cmd, fixed, predicted);
      errors++;
    end
    pending_results.push_back(predicted);
    do @(posedge clk); while (!in_tready);
    sent_ops++;
  endtask

  // Pick an operand, biased toward the byte extremes and decimal-looking values.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4, 5: return {4'($urandom_range(9)), 4'($urandom_range(9))};
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly legal opcodes, with decimal-mode switches and a few unused codes.
  function automatic logic [5:0] pick_cmd();
    int k;
    k = $urandom_range(99);
    if (k < 3)  return 6'($urandom_range(63, 51));
    if (k < 10) return ($urandom_range(1)) ? OP_SED : OP_CLD;
    if (k < 35) return 6'($urandom_range(1));  // extra ADC/SBC weight
    return 6'($urandom_range(OP_NOP));
  endfunction

  // Receiver: random stalls, plus a long hold-off window when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each transferred result with the oldest expectation.
  always @(posedge clk) begin
    exec_result_t want;
    exec_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.mem_value    = out_tdata[7:0];
      got.acc_now      = out_tdata[15:8];
      got.x_now        = out_tdata[23:16];
      got.y_now        = out_tdata[31:24];
      got.flags_now    = out_tdata[39:32];
      got.sp_now       = out_tdata[47:40];
      got.mem_write    = out_tuser[0];
      got.branch_taken = out_tuser[1];
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.mem_value !== want.mem_value) begin
          $error("mem_value: expected %h, got %h", want.mem_value, got.mem_value);
          errors++;
        end
        if (got.mem_write !== want.mem_write) begin
          $error("mem_write: expected %b, got %b", want.mem_write, got.mem_write);
          errors++;
        end
        if (got.branch_taken !== want.branch_taken) begin
          $error("branch_taken: expected %b, got %b", want.branch_taken, got.branch_taken);
          errors++;
        end
        if (got.acc_now !== want.acc_now) begin
          $error("acc_now: expected %h, got %h", want.acc_now, got.acc_now);
          errors++;
        end
        if (got.x_now !== want.x_now) begin
          $error("x_now: expected %h, got %h", want.x_now, got.x_now);
          errors++;
        end
        if (got.y_now !== want.y_now) begin
          $error("y_now: expected %h, got %h", want.y_now, got.y_now);
          errors++;
        end
        if (got.flags_now !== want.flags_now) begin
          $error("flags_now: expected %h, got %h", want.flags_now, got.flags_now);
          errors++;
        end
        if (got.sp_now !== want.sp_now) begin
          $error("sp_now: expected %h, got %h", want.sp_now, got.sp_now);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run at a generous cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("eight_bit_cpu_execute_unit regression: fail");
      $finish;
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering.
  initial begin
    wait (sent_ops >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result fields: mem_value, mem_write, branch_taken, A, X, Y, P, SP.
  directed_row_t dir_rows[] = '{
    '{OP_NOP, 8'h00, 1, '{8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h36, 8'hFF}},
    '{OP_LDA, 8'hFF, 1, '{8'h00, 0, 0, 8'hFF, 8'h00, 8'h00, 8'hB4, 8'hFF}},
    '{OP_LDX, 8'h00, 1, '{8'h00, 0, 0, 8'hFF, 8'h00, 8'h00, 8'h36, 8'hFF}},
    '{OP_DEX, 8'h00, 1, '{8'h00, 0, 0, 8'hFF, 8'hFF, 8'h00, 8'hB4, 8'hFF}},
    '{OP_ADC, 8'h01, 0, '0},
    '{OP_SBC, 8'h80, 0, '0},
    '{OP_SED, 8'h00, 0, '0},
    '{OP_ADC, 8'h99, 0, '0},
    '{OP_SBC, 8'h09, 0, '0},
    '{OP_CLD, 8'h00, 0, '0},
    '{OP_BIT, 8'hC0, 0, '0},
    '{OP_BVS, 8'h00, 0, '0},
    '{OP_CMP, 8'h7F, 0, '0},
    '{OP_ROLM, 8'h80, 0, '0},
    '{OP_RORA, 8'h00, 0, '0},
    '{OP_INC, 8'hFF, 0, '0},
    '{OP_DEC, 8'h00, 0, '0},
    '{OP_LDY, 8'h80, 0, '0},
    '{OP_TXS, 8'h00, 0, '0},
    '{OP_TSX, 8'h00, 0, '0},
    '{OP_STY, 8'hAA, 0, '0},
    '{OP_BPL, 8'h00, 0, '0},
    '{6'd63, 8'h55, 0, '0}
  };

  initial begin
    int n;
    errors = 0; cycles = 0; sent_ops = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00; cpu_sp = SpReset; cpu_p = FlagsReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_op(dir_rows[i].cmd, dir_rows[i].operand, dir_rows[i].check_fixed,
              dir_rows[i].fixed);
    in_tvalid <= 1'b0;

    // Pause until every result is back.
    wait (pending_results.size() == 0);
    @(posedge clk);

    for (n = 0; n < RandomOps; n++) begin
      case (n * 5 / RandomOps)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin
          send_idle_pct = $urandom_range(1) ? 0 : 30;
          recv_stall_pct = $urandom_range(1) ? 0 : 30;
        end
      endcase
      send_op(pick_cmd(), pick_operand(), 0, '0);
    end
    in_tvalid <= 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;

    // Drain, then allow the pipeline latency to settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("eight_bit_cpu_execute_unit regression: pass");
    else
      $display("eight_bit_cpu_execute_unit regression: fail");
    $finish;
  end
endmodule
